### rtl/core/sorted_priority_queue_unit_macros.svh
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int DATA_W = 8;
  localparam int PRIO_W = 8;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 4;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic {
    SPQ_IDLE,
    SPQ_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

### rtl/core/sorted_priority_queue_unit.sv
// Sorted priority queue of up to DEPTH entries (data byte plus priority), kept in
// ascending priority order with equal priorities leaving first in, first out.
// Issue a request by raising start while busy is low; the request is latched
// in SPQ_IDLE, then in SPQ_EXEC every slot compares its priority against the
// new one in parallel and the whole row shifts to insert or remove. The
// result appears on the out_ ports for exactly one cycle with out_valid high, in
// the cycle after the operation, and cannot be held off; a new request may be
// issued in that same cycle, but not while the previous one is executing.
// out_occupancy reports the entry count after the operation, modulo 16.
`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_kind,
  input  logic [DATA_W-1:0] in_item_data,
  input  logic [PRIO_W-1:0] in_item_priority,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [DATA_W-1:0] out_data,
  output logic [PRIO_W-1:0] out_priority,
  output logic [OCC_W-1:0]  out_occupancy
);

  cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_kind          (in_kind),
    .in_item_data     (in_item_data),
    .in_item_priority (in_item_priority),
    .out_status       (out_status),
    .out_data         (out_data),
    .out_priority     (out_priority),
    .out_occupancy    (out_occupancy)
  );

  `SPQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_valid, "request not held busy")
  `SPQ_ASSERT_NEXT(a_result_follows, clk, rst_n, busy, out_valid && !busy, "result strobe missing")
  `SPQ_ASSERT_SAME(a_underflow_empty, clk, rst_n, out_valid && (out_status == ST_UNDERFLOW), (out_occupancy == '0) && (out_data == '0) && (out_priority == '0), "underflow with entries held")
  `SPQ_ASSERT_SAME(a_overflow_full, clk, rst_n, out_valid && (out_status == ST_OVERFLOW), out_occupancy == OCC_W'(DEPTH), "overflow while not full")

endmodule

### rtl/core/spq_ctrl.sv
module spq_ctrl
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output logic out_valid,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SPQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      SPQ_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = SPQ_EXEC;
        end
      end
      SPQ_EXEC: begin
        cmd.exec      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = SPQ_IDLE;
      end
      default: begin
        state_nxt = SPQ_IDLE;
      end
    endcase
  end

  assign busy      = (state_r == SPQ_EXEC);
  assign out_valid = out_valid_r;

endmodule

### rtl/core/spq_datapath.sv
module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic              in_kind,
  input  logic [DATA_W-1:0] in_item_data,
  input  logic [PRIO_W-1:0] in_item_priority,
  output logic [STAT_W-1:0] out_status,
  output logic [DATA_W-1:0] out_data,
  output logic [PRIO_W-1:0] out_priority,
  output logic [OCC_W-1:0]  out_occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  logic              req_kind_r;
  logic [DATA_W-1:0] req_data_r;
  logic [PRIO_W-1:0] req_prio_r;

  logic [DATA_W-1:0] ent_data_r   [DEPTH];
  logic [PRIO_W-1:0] ent_prio_r   [DEPTH];
  logic [DATA_W-1:0] ent_data_nxt [DEPTH];
  logic [PRIO_W-1:0] ent_prio_nxt [DEPTH];
  logic [DATA_W-1:0] up_data      [DEPTH];
  logic [PRIO_W-1:0] up_prio      [DEPTH];
  logic [DATA_W-1:0] dn_data      [DEPTH];
  logic [PRIO_W-1:0] dn_prio      [DEPTH];

  logic [CW-1:0]     count_r, count_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;
  logic [PRIO_W-1:0] res_prio_r, res_prio_nxt;

  logic [DEPTH-1:0]  gt;
  logic [DEPTH-1:0]  gt_prev;
  logic              full;
  logic              empty;
  logic              do_enq;
  logic              do_deq;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_enq  = cmd.exec && (req_kind_r == KIND_ENQ) && !full;
  assign do_deq  = cmd.exec && (req_kind_r == KIND_DEQ) && !empty;
  assign gt_prev = {gt[DEPTH-2:0], 1'b0};

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i]      = (CW'(i) < count_r) && (ent_prio_r[i] > req_prio_r);
      up_data[i] = ent_data_r[i];
      up_prio[i] = ent_prio_r[i];
      dn_data[i] = ent_data_r[i];
      dn_prio[i] = ent_prio_r[i];
    end
    for (int i = 1; i < DEPTH; i++) begin
      up_data[i] = ent_data_r[i-1];
      up_prio[i] = ent_prio_r[i-1];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      dn_data[i] = ent_data_r[i+1];
      dn_prio[i] = ent_prio_r[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_data_nxt[i] = ent_data_r[i];
      ent_prio_nxt[i] = ent_prio_r[i];
      if (do_enq) begin
        if (gt_prev[i]) begin
          ent_data_nxt[i] = up_data[i];
          ent_prio_nxt[i] = up_prio[i];
        end else if (gt[i] || (CW'(i) == count_r)) begin
          ent_data_nxt[i] = req_data_r;
          ent_prio_nxt[i] = req_prio_r;
        end
      end else if (do_deq) begin
        ent_data_nxt[i] = dn_data[i];
        ent_prio_nxt[i] = dn_prio[i];
      end
    end
  end

  always_comb begin
    count_nxt    = count_r;
    status_nxt   = status_r;
    res_data_nxt = res_data_r;
    res_prio_nxt = res_prio_r;
    if (cmd.exec) begin
      status_nxt   = ST_DONE;
      res_data_nxt = '0;
      res_prio_nxt = '0;
      if (req_kind_r == KIND_ENQ) begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end else begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          count_nxt    = count_r - CW'(1);
          res_data_nxt = ent_data_r[0];
          res_prio_nxt = ent_prio_r[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind_r <= in_kind;
      req_data_r <= in_item_data;
      req_prio_r <= in_item_priority;
    end
    status_r   <= status_nxt;
    res_data_r <= res_data_nxt;
    res_prio_r <= res_prio_nxt;
    for (int i = 0; i < DEPTH; i++) begin
      ent_data_r[i] <= ent_data_nxt[i];
      ent_prio_r[i] <= ent_prio_nxt[i];
    end
  end

  assign out_status    = status_r;
  assign out_data      = res_data_r;
  assign out_priority  = res_prio_r;
  assign out_occupancy = OCC_W'(count_r);

endmodule
